// ----- rtl/swbi_pkg.sv -----
`default_nettype none

package swbi_pkg;

  localparam int DEPTH = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_INC  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] operand_value;
    logic [15:0]        bottom_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               was_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_WR,
    ST_POP_EMPTY,
    ST_POP_RD_TOP,
    ST_POP_RD_NEXT,
    ST_POP_WB,
    ST_POP_OUT,
    ST_INC_RD,
    ST_INC_WR
  } state_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_WR,
    OP_POP_EMPTY,
    OP_POP_RD_TOP,
    OP_POP_RD_NEXT,
    OP_POP_WB,
    OP_POP_OUT,
    OP_INC_RD,
    OP_INC_WR
  } dp_op_t;

  typedef struct packed {
    logic [1:0] action;
    logic       push_ok;
    logic       count_zero;
    logic       k_zero;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/swbi_ctrl.sv -----
`default_nettype none

module swbi_ctrl
  import swbi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.action)
          ACT_PUSH: state_next = status.push_ok ? ST_PUSH_WR : ST_IDLE;
          ACT_POP:  state_next = status.count_zero ? ST_POP_EMPTY : ST_POP_RD_TOP;
          ACT_INC: begin
            state_next = (status.count_zero || status.k_zero) ? ST_IDLE : ST_INC_RD;
          end
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PUSH_WR:     state_next = ST_IDLE;
      ST_POP_EMPTY:   state_next = ST_POP_OUT;
      ST_POP_RD_TOP:  state_next = ST_POP_RD_NEXT;
      ST_POP_RD_NEXT: state_next = ST_POP_WB;
      ST_POP_WB:      state_next = ST_POP_OUT;
      ST_POP_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_INC_RD:      state_next = ST_INC_WR;
      ST_INC_WR:      state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
        end
      end
      ST_DECODE:      op = OP_NONE;
      ST_PUSH_WR:     op = OP_PUSH_WR;
      ST_POP_EMPTY:   op = OP_POP_EMPTY;
      ST_POP_RD_TOP:  op = OP_POP_RD_TOP;
      ST_POP_RD_NEXT: op = OP_POP_RD_NEXT;
      ST_POP_WB:      op = OP_POP_WB;
      ST_POP_OUT: begin
        if (status.out_free) begin
          op = OP_POP_OUT;
        end
      end
      ST_INC_RD:      op = OP_INC_RD;
      ST_INC_WR:      op = OP_INC_WR;
      default:        op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/swbi_datapath.sv -----
`default_nettype none

module swbi_datapath
  import swbi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  input  wire dp_op_t           op,
  output dp_status_t            status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  logic [31:0] stored_mem [DEPTH];
  logic [31:0] pend_mem [DEPTH];

  in_item_t         item;
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] capacity;
  logic [31:0]      stored_rd;
  logic [31:0]      pend_rd;
  logic [31:0]      sum;
  logic [31:0]      inc;
  logic             empty;

  logic [31:0]       limit;
  logic [31:0]       k_min;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W-1:0] inc_addr;
  logic              stored_we;
  logic              stored_re;
  logic              pend_we;
  logic              pend_re;
  logic [ADDR_W-1:0] stored_addr;
  logic [ADDR_W-1:0] pend_addr;
  logic [31:0]       pend_wdata;
  logic              out_free;

  assign limit = (32'(capacity) < 32'(DEPTH)) ? 32'(capacity) : 32'(DEPTH);
  assign k_min = (32'(item.bottom_count) < 32'(count)) ? 32'(item.bottom_count)
                                                      : 32'(count);
  assign top_addr  = ADDR_W'(count - CNT_W'(1));
  assign next_addr = ADDR_W'(count - CNT_W'(2));
  assign inc_addr  = ADDR_W'(k_min - 32'd1);
  assign out_free  = !out_valid || out_ready;

  assign status.action     = item.action;
  assign status.push_ok    = 32'(count) < limit;
  assign status.count_zero = (count == '0);
  assign status.k_zero     = (item.bottom_count == '0);
  assign status.out_free   = out_free;

  always_comb begin
    stored_we   = 1'b0;
    stored_re   = 1'b0;
    pend_we     = 1'b0;
    pend_re     = 1'b0;
    stored_addr = top_addr;
    pend_addr   = top_addr;
    pend_wdata  = '0;
    case (op)
      OP_PUSH_WR: begin
        stored_we   = 1'b1;
        pend_we     = 1'b1;
        stored_addr = ADDR_W'(count);
        pend_addr   = ADDR_W'(count);
      end
      OP_POP_RD_TOP: begin
        stored_re = 1'b1;
        pend_re   = 1'b1;
      end
      OP_POP_RD_NEXT: begin
        pend_re   = 1'b1;
        pend_addr = next_addr;
      end
      OP_POP_WB: begin
        // The popped entry's increment moves down to the new top entry.
        pend_we    = (count > CNT_W'(1));
        pend_addr  = next_addr;
        pend_wdata = pend_rd + inc;
      end
      OP_INC_RD: begin
        pend_re   = 1'b1;
        pend_addr = inc_addr;
      end
      OP_INC_WR: begin
        pend_we    = 1'b1;
        pend_addr  = inc_addr;
        pend_wdata = pend_rd + item.operand_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stored_we) begin
      stored_mem[stored_addr] <= item.operand_value;
    end
    if (stored_re) begin
      stored_rd <= stored_mem[stored_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_addr] <= pend_wdata;
    end
    if (pend_re) begin
      pend_rd <= pend_mem[pend_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      item <= in_data;
    end
    if (op == OP_POP_EMPTY) begin
      sum   <= '1;
      empty <= 1'b1;
    end else if (op == OP_POP_RD_NEXT) begin
      sum   <= stored_rd + pend_rd;
      inc   <= pend_rd;
      empty <= 1'b0;
    end
    if (op == OP_POP_OUT) begin
      out_data.popped_value <= sum;
      out_data.was_empty    <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (op == OP_PUSH_WR) begin
        count <= count + CNT_W'(1);
      end else if (op == OP_POP_WB) begin
        count <= count - CNT_W'(1);
      end
      if (op == OP_POP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stack_with_bottom_increment.sv -----
`default_nettype none

// Bounded stack of 32-bit values with an "add to the bottom k entries"
// operation, kept lazily as a pending increment per entry. Items are taken
// one at a time: a new item is not taken until the last one is finished, and
// a pop may also wait for the output register to free up. The value and
// increment memories are single-port, so a pop must read the top entry, read
// the entry below it and write that entry back in turn. A finished pop
// result sits in an output register, so the next item is taken while it
// waits for transfer.
// Capacity is written through cfg_wr_en/cfg_wr_data; the user must do this
// only while the block is idle, as the block does not enforce it. It resets
// to 1024; a pop on an empty stack returns -1 with was_empty set.
module stack_with_bottom_increment
  import swbi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data
);

  dp_op_t     op;
  dp_status_t status;

  swbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  swbi_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (op),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
